// File: hdl/tmob_pkg.sv
// Shared types, constants and function tables for the mixed-order basis evaluator.
// Holds the microcode decoder, operand addressing and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package tmob_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DW        = 32;   // operand width
  localparam int RW        = 48;   // result width
  localparam int AW        = 52;   // exact accumulator width
  localparam int XW        = 49;   // cross product accumulator width
  localparam int PW        = 80;   // full product width in the multiplier
  localparam logic [4:0] LAST_FUNC = 5'd19;

  localparam logic signed [RW-1:0] MAX48 = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] MIN48 = {1'b1, {(RW-1){1'b0}}};

  typedef enum logic [1:0] {SRC_L, SRC_G, SRC_P, SRC_X} src_t;
  typedef enum logic [1:0] {DST_B, DST_X, DST_P, DST_C} dst_t;
  typedef enum logic [1:0] {CF_P1, CF_M1, CF_M2, CF_M3} coef_t;

  typedef struct packed {
    logic       is_mul;
    src_t       a_src;
    logic [1:0] a_row;
    logic [1:0] a_comp;
    src_t       b_src;
    logic [1:0] b_row;
    logic [1:0] b_comp;
    dst_t       dst;
    coef_t      coef;
    logic       curl_x2;
  } uop_t;

  typedef struct packed {
    logic [3:0] addr_a;
    logic [3:0] addr_b;
  } rd_req_t;

  typedef struct packed {
    logic          en;
    logic [3:0]    addr;
    logic [DW-1:0] data;
  } wr_req_t;

  // face terms: barycentric pair, gradient row; third term scaled by -2
  localparam logic [1:0] FACE_TAB [8][3][3] = '{
    '{'{2'd1, 2'd2, 2'd0}, '{2'd0, 2'd2, 2'd1}, '{2'd0, 2'd1, 2'd2}},
    '{'{2'd1, 2'd3, 2'd0}, '{2'd0, 2'd3, 2'd1}, '{2'd0, 2'd1, 2'd3}},
    '{'{2'd2, 2'd3, 2'd0}, '{2'd0, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd3}},
    '{'{2'd2, 2'd3, 2'd1}, '{2'd1, 2'd3, 2'd2}, '{2'd1, 2'd2, 2'd3}},
    '{'{2'd2, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd2}, '{2'd1, 2'd2, 2'd0}},
    '{'{2'd3, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd3}, '{2'd1, 2'd3, 2'd0}},
    '{'{2'd3, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd3}, '{2'd2, 2'd3, 2'd0}},
    '{'{2'd3, 2'd1, 2'd2}, '{2'd2, 2'd1, 2'd3}, '{2'd2, 2'd3, 2'd1}}
  };

  // face curl terms: barycentric index, then cross of two gradient rows; scaled by -3
  localparam logic [1:0] FCURL_TAB [8][2][3] = '{
    '{'{2'd1, 2'd0, 2'd2}, '{2'd0, 2'd1, 2'd2}},
    '{'{2'd1, 2'd0, 2'd3}, '{2'd0, 2'd1, 2'd3}},
    '{'{2'd2, 2'd0, 2'd3}, '{2'd0, 2'd2, 2'd3}},
    '{'{2'd2, 2'd1, 2'd3}, '{2'd1, 2'd2, 2'd3}},
    '{'{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd2, 2'd0}},
    '{'{2'd3, 2'd1, 2'd0}, '{2'd1, 2'd3, 2'd0}},
    '{'{2'd3, 2'd2, 2'd0}, '{2'd2, 2'd3, 2'd0}},
    '{'{2'd3, 2'd2, 2'd1}, '{2'd2, 2'd3, 2'd1}}
  };

  function automatic logic [1:0] edge_a(input logic [2:0] e);
    logic [1:0] r;
    case (e)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] edge_b(input logic [2:0] e);
    logic [1:0] r;
    case (e)
      3'd0:       r = 2'd1;
      3'd1, 3'd3: r = 2'd2;
      default:    r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot1(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot2(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // operand store address of a barycentric value or a gradient entry
  function automatic logic [3:0] slot_addr(input src_t src, input logic [1:0] row,
                                           input logic [1:0] comp);
    logic [6:0] g;
    g = 7'd4 + 7'(row) * 7'd3 + 7'(comp);
    return (src == SRC_L) ? {2'b00, row} : g[3:0];
  endfunction

  function automatic logic signed [RW-1:0] sat48(input logic signed [AW-1:0] v);
    logic signed [RW-1:0] r;
    if (v > AW'(MAX48))      r = MAX48;
    else if (v < AW'(MIN48)) r = MIN48;
    else                     r = v[RW-1:0];
    return r;
  endfunction

  // multiply a 48-bit value by one of the constant factors, exactly
  function automatic logic signed [AW-1:0] scale(input coef_t c, input logic signed [RW-1:0] y);
    logic signed [AW-1:0] e;
    logic signed [AW-1:0] r;
    e = {{(AW-RW){y[RW-1]}}, y};
    unique case (c)
      CF_P1: r = e;
      CF_M1: r = -e;
      CF_M2: r = -(e <<< 1);
      CF_M3: r = -(e + (e <<< 1));
    endcase
    return r;
  endfunction

  // microcode: one operation of function f, component k, step
  function automatic uop_t decode(input logic [4:0] f, input logic [1:0] k,
                                  input logic [3:0] step);
    uop_t       u;
    logic [1:0] k1, k2, ea, eb, t, c0, c1, c2;
    logic [2:0] e, j;
    logic [3:0] s, r;
    logic       ct, ui;
    u  = '0;
    k1 = rot1(k);
    k2 = rot2(k);
    if (f < 5'd12) begin
      ct = (f < 5'd6);
      e  = ct ? f[2:0] : 3'(f - 5'd6);
      ea = edge_a(e);
      eb = edge_b(e);
      case (step)
        4'd0: begin
          u.is_mul = 1'b1; u.a_src = SRC_L; u.a_row = ea;
          u.b_src = SRC_G; u.b_row = eb; u.b_comp = k; u.dst = DST_B; u.coef = CF_P1;
        end
        4'd1: begin
          u.is_mul = 1'b1; u.a_src = SRC_L; u.a_row = eb;
          u.b_src = SRC_G; u.b_row = ea; u.b_comp = k; u.dst = DST_B;
          u.coef = ct ? CF_M1 : CF_P1;
        end
        4'd2: begin
          if (ct) begin
            u.is_mul = 1'b1; u.a_src = SRC_G; u.a_row = ea; u.a_comp = k1;
            u.b_src = SRC_G; u.b_row = eb; u.b_comp = k2; u.dst = DST_X; u.coef = CF_P1;
          end
        end
        4'd3: begin
          if (ct) begin
            u.is_mul = 1'b1; u.a_src = SRC_G; u.a_row = ea; u.a_comp = k2;
            u.b_src = SRC_G; u.b_row = eb; u.b_comp = k1; u.dst = DST_X; u.coef = CF_M1;
          end
        end
        default: u.curl_x2 = ct;
      endcase
    end else begin
      j = 3'(f - 5'd12);
      t = step[2:1];
      if (step < 4'd6) begin
        u.is_mul = 1'b1;
        if (!step[0]) begin
          u.a_src = SRC_L; u.a_row = FACE_TAB[j][t][0];
          u.b_src = SRC_L; u.b_row = FACE_TAB[j][t][1]; u.dst = DST_P;
        end else begin
          u.a_src = SRC_P;
          u.b_src = SRC_G; u.b_row = FACE_TAB[j][t][2]; u.b_comp = k;
          u.dst = DST_B; u.coef = (t == 2'd2) ? CF_M2 : CF_P1;
        end
      end else if (step < 4'd12) begin
        s  = step - 4'd6;
        ui = (s >= 4'd3);
        r  = ui ? s - 4'd3 : s;
        c0 = FCURL_TAB[j][ui][0];
        c1 = FCURL_TAB[j][ui][1];
        c2 = FCURL_TAB[j][ui][2];
        u.is_mul = 1'b1;
        case (r)
          4'd0: begin
            u.a_src = SRC_G; u.a_row = c1; u.a_comp = k1;
            u.b_src = SRC_G; u.b_row = c2; u.b_comp = k2; u.dst = DST_X; u.coef = CF_P1;
          end
          4'd1: begin
            u.a_src = SRC_G; u.a_row = c1; u.a_comp = k2;
            u.b_src = SRC_G; u.b_row = c2; u.b_comp = k1; u.dst = DST_X; u.coef = CF_M1;
          end
          default: begin
            u.a_src = SRC_X;
            u.b_src = SRC_L; u.b_row = c0; u.dst = DST_C; u.coef = CF_M3;
          end
        endcase
      end
    end
    return u;
  endfunction

endpackage

// File: hdl/tmob_opmem.sv
// Operand store: four barycentric values and twelve gradient entries.
// One write port, two registered read ports; unwritten entries read as zero.
// Depends on tmob_pkg.
`timescale 1ns / 1ps

module tmob_opmem
  import tmob_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  wr_req_t       wr,
  input  rd_req_t       rd,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem_r [16];
  logic [15:0]   vld_r;
  logic [DW-1:0] rdata_a_r, rdata_b_r;

  // track which entries have been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // write and register both reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rdata_a_r <= vld_r[rd.addr_a] ? mem_r[rd.addr_a] : '0;
    rdata_b_r <= vld_r[rd.addr_b] ? mem_r[rd.addr_b] : '0;
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: hdl/tmob_qmul.sv
// Shared fixed-point multiplier: 48 x 32 bit signed, rounded and saturated to 48 bits.
// One 32 x 32 multiplier used twice, low half then high half; the result is registered.
// Depends on tmob_pkg.
`timescale 1ns / 1ps

module tmob_qmul
  import tmob_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [RW-1:0] a,
  input  logic signed [DW-1:0] b,
  output logic                 done,
  output logic signed [RW-1:0] y
);

  logic [2:0]           v_r;
  logic                 done_r;
  logic [RW-1:0]        m_r;
  logic [DW-1:0]        n_r;
  logic                 neg_r;
  logic [2*DW-1:0]      pl_r;
  logic [RW-1:0]        ph_r;
  logic signed [RW-1:0] y_r;
  logic [DW-1:0]        mop;
  logic [2*DW-1:0]      prod;
  logic [PW-1:0]        sum;
  logic [PW-1:0]        rnd;
  logic signed [RW-1:0] y_nxt;

  // advance the phase pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      done_r <= 1'b0;
    end else begin
      v_r    <= {v_r[1:0], start};
      done_r <= v_r[2];
    end
  end

  // low half first, then high half through the same multiplier
  assign mop  = v_r[1] ? {{(2*DW-RW){1'b0}}, m_r[RW-1:DW]} : m_r[DW-1:0];
  assign prod = mop * n_r;

  // combine, round to nearest with ties away from zero, saturate
  always_comb begin
    sum = {ph_r, {DW{1'b0}}} + PW'(pl_r) + (PW'(1) << (FRAC_BITS - 1));
    rnd = sum >> FRAC_BITS;
    if (neg_r) begin
      if (rnd > (PW'(1) << (RW - 1))) y_nxt = MIN48;
      else                            y_nxt = ~rnd[RW-1:0] + 1'b1;
    end else begin
      if (rnd > PW'(MAX48)) y_nxt = MAX48;
      else                  y_nxt = rnd[RW-1:0];
    end
  end

  // hold magnitudes and partial products
  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= a[RW-1] ? ~a + 1'b1 : a;
      n_r   <= b[DW-1] ? ~b + 1'b1 : b;
      neg_r <= a[RW-1] ^ b[DW-1];
    end
    if (v_r[0]) pl_r <= prod;
    if (v_r[1]) ph_r <= prod[RW-1:0];
    if (v_r[2]) y_r  <= y_nxt;
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

// File: hdl/tet_mixed_order_basis_eval_core.sv
// Top level of the mixed-order tetrahedral basis evaluator: sequencer and accumulators.
// Uses tmob_opmem for operands and tmob_qmul as the shared multiplier.
// Depends on tmob_pkg.
//
// Usage:
//   Each input item writes one operand slot (0-3 barycentric, 4-15 gradient) and is
//   accepted on a clock edge with start high and busy low. A plain load leaves busy
//   low, so loads may follow each other in every cycle.
//   An item with in_evaluate set stores its operand, raises busy and produces twenty
//   results in function order, each on the out_ ports for one cycle with out_valid
//   high; out_last marks function nineteen. The receiver cannot stall.
//   Each multiply passes operand fetch, issue and the multiplier before the next one is
//   issued, and the evaluation runs 396 of them plus sixty component closes; busy
//   stays high until the run ends and is low again when the last result appears.
//   The shared multiplier sets the pace of the whole run.
//   Synchronous reset clears the operand store to zero, idles the sequencer and
//   drops out_valid.
`timescale 1ns / 1ps

module tet_mixed_order_basis_eval_core
  import tmob_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           in_slot,
  input  logic signed [DW-1:0] in_operand_value,
  input  logic                 in_evaluate,
  output logic                 out_valid,
  output logic [4:0]           out_function_index,
  output logic signed [RW-1:0] out_basis_x,
  output logic signed [RW-1:0] out_basis_y,
  output logic signed [RW-1:0] out_basis_z,
  output logic signed [RW-1:0] out_curl_x,
  output logic signed [RW-1:0] out_curl_y,
  output logic signed [RW-1:0] out_curl_z,
  output logic                 out_last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [4:0]           f_r, f_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [3:0]           step_r, step_nxt;
  logic signed [AW-1:0] accb_r, accc_r;
  logic signed [XW-1:0] x_r;
  logic signed [RW-1:0] p_r;
  logic signed [RW-1:0] bcomp_r [2];
  logic signed [RW-1:0] ccomp_r [2];
  logic                 out_valid_r;
  logic [4:0]           out_fi_r;
  logic signed [RW-1:0] ob_x_r, ob_y_r, ob_z_r, oc_x_r, oc_y_r, oc_z_r;
  logic                 out_last_r;

  uop_t                 uop;
  rd_req_t              rd;
  wr_req_t              wr;
  logic [DW-1:0]        rdata_a, rdata_b;
  logic signed [RW-1:0] satx, mul_a, mul_y, bv_new, cv_new;
  logic                 mul_start, mul_done, accept, close_op, wb;
  logic signed [AW-1:0] curl_add;

  assign accept   = start && (state_r == ST_IDLE);
  assign uop      = decode(f_r, k_r, step_r);
  assign close_op = (state_r == ST_EXEC) && !uop.is_mul;
  assign wb       = (state_r == ST_WAIT) && mul_done;

  // operand store traffic
  assign wr.en      = accept;
  assign wr.addr    = in_slot;
  assign wr.data    = in_operand_value;
  assign rd.addr_a  = slot_addr(uop.a_src, uop.a_row, uop.a_comp);
  assign rd.addr_b  = slot_addr(uop.b_src, uop.b_row, uop.b_comp);

  tmob_opmem u_opmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // saturated cross product accumulator
  assign satx = (x_r > XW'(MAX48)) ? MAX48 :
                (x_r < XW'(MIN48)) ? MIN48 : x_r[RW-1:0];

  // select the wide multiplier operand
  always_comb begin
    unique case (uop.a_src)
      SRC_L, SRC_G: mul_a = {{(RW-DW){rdata_a[DW-1]}}, rdata_a};
      SRC_P:        mul_a = p_r;
      SRC_X:        mul_a = satx;
    endcase
  end

  assign mul_start = (state_r == ST_EXEC) && uop.is_mul;

  tmob_qmul u_qmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (rdata_b),
    .done  (mul_done),
    .y     (mul_y)
  );

  // component close values
  assign curl_add = uop.curl_x2 ? ({{(AW-RW){satx[RW-1]}}, satx} <<< 1) : '0;
  assign bv_new   = sat48(accb_r);
  assign cv_new   = sat48(accc_r + curl_add);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    f_nxt     = f_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_evaluate) begin
          f_nxt     = '0;
          k_nxt     = '0;
          step_nxt  = '0;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (uop.is_mul) begin
          state_nxt = ST_WAIT;
        end else begin
          step_nxt = '0;
          if (k_r == 2'd2) begin
            k_nxt = '0;
            if (f_r == LAST_FUNC) begin
              state_nxt = ST_IDLE;
            end else begin
              f_nxt     = f_r + 5'd1;
              state_nxt = ST_FETCH;
            end
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_WAIT: begin
        if (mul_done) begin
          step_nxt  = step_r + 4'd1;
          state_nxt = ST_FETCH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      f_r         <= '0;
      k_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      f_r         <= f_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      out_valid_r <= close_op && (k_r == 2'd2);
    end
  end

  // accumulate products; clear at every accepted item and after each component
  always_ff @(posedge clk) begin
    if (accept || close_op) begin
      accb_r <= '0;
      accc_r <= '0;
      x_r    <= '0;
    end else if (wb) begin
      unique case (uop.dst)
        DST_B: accb_r <= accb_r + scale(uop.coef, mul_y);
        DST_X: x_r    <= (uop.coef == CF_M1) ? x_r - XW'(mul_y) : x_r + XW'(mul_y);
        DST_P: p_r    <= mul_y;
        DST_C: begin
          accc_r <= accc_r + scale(uop.coef, mul_y);
          x_r    <= '0;
        end
      endcase
    end
  end

  // hold the first two components, then drive the result
  always_ff @(posedge clk) begin
    if (close_op) begin
      if (k_r == 2'd0) begin
        bcomp_r[0] <= bv_new;
        ccomp_r[0] <= cv_new;
      end
      if (k_r == 2'd1) begin
        bcomp_r[1] <= bv_new;
        ccomp_r[1] <= cv_new;
      end
      if (k_r == 2'd2) begin
        out_fi_r   <= f_r;
        ob_x_r     <= bcomp_r[0];
        ob_y_r     <= bcomp_r[1];
        ob_z_r     <= bv_new;
        oc_x_r     <= ccomp_r[0];
        oc_y_r     <= ccomp_r[1];
        oc_z_r     <= cv_new;
        out_last_r <= (f_r == LAST_FUNC);
      end
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_function_index = out_fi_r;
  assign out_basis_x        = ob_x_r;
  assign out_basis_y        = ob_y_r;
  assign out_basis_z        = ob_z_r;
  assign out_curl_x         = oc_x_r;
  assign out_curl_y         = oc_y_r;
  assign out_curl_z         = oc_z_r;
  assign out_last           = out_last_r;

`ifndef SYNTH
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_WAIT))
    else $error("multiplier finished outside a wait");

  a_eval_raises_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_evaluate) |=> busy)
    else $error("evaluate item did not start the sequencer");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_function_index <= LAST_FUNC))
    else $error("function index out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("last result while still busy");
`endif

endmodule

// File: tb/tb.sv
// Self-checking bench for tet_mixed_order_basis_eval_core: operand loads and evaluations.
// Predicts all twenty basis and curl vectors in fixed point and checks every result.
// Depends on tmob_pkg for the operand and result widths.
`timescale 1ns / 1ps

module tb
  import tmob_pkg::*;
();

  typedef struct {
    logic [3:0]           slot;
    logic signed [DW-1:0] value;
    logic                 evaluate;
    logic                 drain;
  } load_item_t;

  typedef struct {
    logic [4:0]           fn;
    logic signed [RW-1:0] bv [3];
    logic signed [RW-1:0] cv [3];
    logic                 last;
  } basis_result_t;

  localparam longint SAT_HI = 64'sd140737488355327;
  localparam longint SAT_LO = -64'sd140737488355328;
  localparam int     LIMIT_CYCLES = 5000000;

  // edge vertex pairs, face term tables, face curl tables
  localparam int EDGE_A [6] = '{0, 0, 0, 1, 1, 2};
  localparam int EDGE_B [6] = '{1, 2, 3, 2, 3, 3};
  localparam int FACE_T [8][3][3] = '{
    '{'{1, 2, 0}, '{0, 2, 1}, '{0, 1, 2}},
    '{'{1, 3, 0}, '{0, 3, 1}, '{0, 1, 3}},
    '{'{2, 3, 0}, '{0, 3, 2}, '{0, 2, 3}},
    '{'{2, 3, 1}, '{1, 3, 2}, '{1, 2, 3}},
    '{'{2, 0, 1}, '{1, 0, 2}, '{1, 2, 0}},
    '{'{3, 0, 1}, '{1, 0, 3}, '{1, 3, 0}},
    '{'{3, 0, 2}, '{2, 0, 3}, '{2, 3, 0}},
    '{'{3, 1, 2}, '{2, 1, 3}, '{2, 3, 1}}
  };
  localparam int CURL_T [8][2][3] = '{
    '{'{1, 0, 2}, '{0, 1, 2}},
    '{'{1, 0, 3}, '{0, 1, 3}},
    '{'{2, 0, 3}, '{0, 2, 3}},
    '{'{2, 1, 3}, '{1, 2, 3}},
    '{'{2, 1, 0}, '{1, 2, 0}},
    '{'{3, 1, 0}, '{1, 3, 0}},
    '{'{3, 2, 0}, '{2, 3, 0}},
    '{'{3, 2, 1}, '{2, 3, 1}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [3:0]           in_slot = '0;
  logic signed [DW-1:0] in_operand_value = '0;
  logic                 in_evaluate = 1'b0;
  logic                 out_valid;
  logic [4:0]           out_function_index;
  logic signed [RW-1:0] out_basis_x, out_basis_y, out_basis_z;
  logic signed [RW-1:0] out_curl_x, out_curl_y, out_curl_z;
  logic                 out_last;

  load_item_t    pending_loads [$];
  basis_result_t expected_basis [$];
  load_item_t    cur_load;
  longint        bary_val [4];
  longint        grad_val [12];
  int            gap_left = 0;
  int            mismatches = 0;
  int            results_seen = 0;
  int            loads_done = 0;
  int            evals_done = 0;
  int            cycles = 0;

  tet_mixed_order_basis_eval_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint sat_rw(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // exact product, round half away from zero, saturate
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] m, n, r;
    logic         neg;
    neg = (a < 0) != (b < 0);
    m = (a < 0) ? 128'(-a) : 128'(a);
    n = (b < 0) ? 128'(-b) : 128'(b);
    r = (m * n + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) begin
      if (r > (128'd1 << 47)) return SAT_LO;
      return -longint'(r);
    end
    if (r > 128'(SAT_HI)) return SAT_HI;
    return longint'(r);
  endfunction

  function automatic longint grad_cross(input int ra, input int rb, input int k);
    int k1, k2;
    k1 = (k + 1) % 3;
    k2 = (k + 2) % 3;
    return sat_rw(fx_mul(grad_val[ra*3+k1], grad_val[rb*3+k2])
                - fx_mul(grad_val[ra*3+k2], grad_val[rb*3+k1]));
  endfunction

  // store the operand; on evaluate queue all twenty basis/curl results
  task automatic apply_load(input load_item_t it);
    basis_result_t res;
    longint acc, t1, t2, p;
    int j;
    if (it.slot < 4) bary_val[it.slot] = longint'(it.value);
    else grad_val[it.slot - 4] = longint'(it.value);
    loads_done++;
    if (!it.evaluate) return;
    evals_done++;
    for (int f = 0; f < 20; f++) begin
      res.fn = 5'(f);
      res.last = (f == 19);
      for (int k = 0; k < 3; k++) begin
        if (f < 12) begin
          t1 = fx_mul(bary_val[EDGE_A[f%6]], grad_val[EDGE_B[f%6]*3+k]);
          t2 = fx_mul(bary_val[EDGE_B[f%6]], grad_val[EDGE_A[f%6]*3+k]);
          if (f < 6) begin
            res.bv[k] = RW'(sat_rw(t1 - t2));
            res.cv[k] = RW'(sat_rw(2 * grad_cross(EDGE_A[f], EDGE_B[f], k)));
          end else begin
            res.bv[k] = RW'(sat_rw(t1 + t2));
            res.cv[k] = '0;
          end
        end else begin
          j = f - 12;
          acc = 0;
          for (int t = 0; t < 3; t++) begin
            p = fx_mul(bary_val[FACE_T[j][t][0]], bary_val[FACE_T[j][t][1]]);
            p = fx_mul(p, grad_val[FACE_T[j][t][2]*3+k]);
            acc += (t == 2) ? -2 * p : p;
          end
          res.bv[k] = RW'(sat_rw(acc));
          acc = 0;
          for (int t = 0; t < 2; t++)
            acc += -3 * fx_mul(grad_cross(CURL_T[j][t][1], CURL_T[j][t][2], k),
                               bary_val[CURL_T[j][t][0]]);
          res.cv[k] = RW'(sat_rw(acc));
        end
      end
      expected_basis.push_back(res);
    end
  endtask

  task automatic add_load(input int slot, input logic signed [DW-1:0] v,
                          input logic ev, input logic dr);
    load_item_t it;
    it.slot = 4'(slot);
    it.value = v;
    it.evaluate = ev;
    it.drain = dr;
    pending_loads.push_back(it);
  endtask

  function automatic logic signed [DW-1:0] draw_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2:       return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
      default: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
    endcase
  endfunction

  // offer items; after each accepted item wait a random gap
  always @(posedge clk) begin
    logic fire;
    fire = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !fire)) begin
      if (fire) begin
        apply_load(cur_load);
        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_loads.size() != 0 &&
                   !(pending_loads[0].drain && expected_basis.size() != 0)) begin
        cur_load = pending_loads.pop_front();
        in_slot <= cur_load.slot;
        in_operand_value <= cur_load.value;
        in_evaluate <= cur_load.evaluate;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [RW-1:0] exp_v,
                             input logic [RW-1:0] got_v, input int fn);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch fn %0d %s: expected %h got %h", fn, name, exp_v, got_v);
    end
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    basis_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_basis.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result fn %0d", out_function_index);
      end else begin
        e = expected_basis.pop_front();
        check_field("function_index", RW'(e.fn), RW'(out_function_index), e.fn);
        check_field("basis_x", e.bv[0], out_basis_x, e.fn);
        check_field("basis_y", e.bv[1], out_basis_y, e.fn);
        check_field("basis_z", e.bv[2], out_basis_z, e.fn);
        check_field("curl_x", e.cv[0], out_curl_x, e.fn);
        check_field("curl_y", e.cv[1], out_curl_y, e.fn);
        check_field("curl_z", e.cv[2], out_curl_z, e.fn);
        check_field("last", RW'(e.last), RW'(out_last), e.fn);
      end
    end
  end

  // hard stop on a hung block
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int n;
    int order [16];
    foreach (bary_val[i]) bary_val[i] = 0;
    foreach (grad_val[i]) grad_val[i] = 0;

    // evaluate straight from reset, then all operands at full scale
    add_load(0, 32'sd0, 1'b1, 1'b0);
    for (int s = 0; s < 16; s++) add_load(s, 32'sh7FFFFFFF, s == 15, 1'b0);
    // mix in the most negative value
    add_load(0, 32'sh80000000, 1'b0, 1'b0);
    add_load(5, 32'sh80000000, 1'b0, 1'b0);
    add_load(9, 32'sh80000000, 1'b0, 1'b0);
    add_load(2, 32'sh80000000, 1'b1, 1'b0);
    add_load(14, 32'sh01000000, 1'b0, 1'b0);
    add_load(1, 32'shFF000000, 1'b1, 1'b0);
    n = pending_loads.size();

    // random part: full operand sets in random order, with stray loads and evaluates
    while (n < 400) begin
      if ($urandom_range(0, 3) != 0) begin
        foreach (order[i]) order[i] = i;
        order.shuffle();
        foreach (order[i])
          add_load(order[i], draw_operand(), i == 15, (i == 0) && (n > 200) && (n < 240));
        n += 16;
      end else begin
        add_load($urandom_range(0, 15), draw_operand(), $urandom_range(0, 5) == 0, 1'b0);
        n++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_loads.size() == 0 && !start);
    wait (expected_basis.size() == 0);
    repeat (200) @(posedge clk);

    $display("%0d items loaded, %0d evaluations, %0d results checked, %0d mismatches",
             loads_done, evals_done, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
